@@ sv/physical_page_bitmap_allocator_core_defines.svh @@
// Assertion macros used by the page bitmap allocator sequencer.
`ifndef PHYSICAL_PAGE_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define PHYSICAL_PAGE_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PPBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: property failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PPBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: property failed");

`endif

@@ sv/ppba_pkg.sv @@
// Shared constants, command codes and byte helpers of the page bitmap allocator.
package ppba_pkg;

	// Default map size in pages.
	localparam int PAGE_COUNT_DEF = 65536;

	// Field widths.
	localparam int CMD_W   = 3;
	localparam int PAGE_W  = 16;
	localparam int GROUP_W = 13;
	localparam int FRAME_W = 16;
	localparam int COUNT_W = 17;

	// Search start after reset.
	localparam logic [GROUP_W-1:0] START_RESET = 13'd256;

	// A group byte with every page claimed.
	localparam logic [7:0] BYTE_FULL = 8'hFF;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_CHECK     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CLAIM     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FIND      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COUNT     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLAIM_ALL = 3'd5;

	// Index of the lowest clear bit; only meaningful when some bit is clear.
	function automatic logic [2:0] lowest_zero(input logic [7:0] b);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!b[i]) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

	// Number of clear bits in a group byte.
	function automatic logic [3:0] zero_count(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'd0, ~b[i]};
		end
		return n;
	endfunction

endpackage

@@ sv/ppba_map_ram.sv @@
// Single-port-write, registered-read memory holding the page group bytes.
module ppba_map_ram #(
	parameter int DEPTH = ppba_pkg::PAGE_COUNT_DEF / 8,
	parameter int AW    = $clog2(ppba_pkg::PAGE_COUNT_DEF / 8)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// Write and read in the same clocked block; read data is registered and shows in the cycle after the read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/ppba_ctrl.sv @@
// Command sequencer: read-modify-write, map walks, fill sweep and result registers.
`include "physical_page_bitmap_allocator_core_defines.svh"

module ppba_ctrl #(
	parameter int PAGE_COUNT = ppba_pkg::PAGE_COUNT_DEF,
	localparam int GROUP_COUNT = PAGE_COUNT / 8,
	localparam int AW = $clog2(GROUP_COUNT)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ppba_pkg::CMD_W-1:0]     command,
	input  logic [ppba_pkg::PAGE_W-1:0]    page,
	input  logic [ppba_pkg::GROUP_W-1:0]   start_group,
	output logic                           busy,
	output logic                           mem_re,
	output logic [AW-1:0]                  mem_raddr,
	input  logic [7:0]                     mem_rdata,
	output logic                           mem_we,
	output logic [AW-1:0]                  mem_waddr,
	output logic [7:0]                     mem_wdata,
	output logic                           done,
	output logic                           page_used,
	output logic [7:0]                     group_bits,
	output logic                           found,
	output logic [ppba_pkg::FRAME_W-1:0]   free_frame,
	output logic [ppba_pkg::COUNT_W-1:0]   free_count
);

	localparam int CNT_W = $clog2(PAGE_COUNT + 1);
	localparam logic [AW-1:0] LAST = AW'(GROUP_COUNT - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RMW  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_FILL = 4'b1000
	} ppba_state_t;

	ppba_state_t state_q;
	logic [AW-1:0] fill_q;
	logic pend_q;
	logic done_q;

	logic [ppba_pkg::CMD_W-1:0] op_q;
	logic in_range_q;
	logic [2:0] bit_q;
	logic [AW-1:0] addr_q;
	logic [CNT_W-1:0] acc_q;

	logic page_used_q;
	logic [7:0] group_bits_q;
	logic found_q;
	logic [ppba_pkg::FRAME_W-1:0] free_frame_q;
	logic [ppba_pkg::COUNT_W-1:0] free_count_q;

	logic accept;
	logic page_in;
	logic start_in;
	logic [AW-1:0] page_addr;
	logic [AW-1:0] start_addr;
	logic [7:0] mask;
	logic [7:0] new_byte;
	logic single_op;
	logic hit;
	logic at_last;
	logic scan_end;
	logic [CNT_W-1:0] acc_next;

	// Decode of the incoming word.
	assign accept     = start && (state_q == ST_IDLE);
	assign page_in    = 32'(page) < 32'(PAGE_COUNT);
	assign start_in   = 32'(start_group) < 32'(GROUP_COUNT);
	assign page_addr  = AW'(page >> 3);
	assign start_addr = AW'(start_group);
	assign busy       = (state_q != ST_IDLE);

	// Modify step of check, claim and release.
	assign single_op = (op_q == ppba_pkg::CMD_CHECK) || (op_q == ppba_pkg::CMD_CLAIM) ||
		(op_q == ppba_pkg::CMD_RELEASE);
	assign mask = 8'd1 << bit_q;
	always_comb begin
		case (op_q)
			ppba_pkg::CMD_CLAIM:   new_byte = mem_rdata | mask;
			ppba_pkg::CMD_RELEASE: new_byte = mem_rdata & ~mask;
			default:               new_byte = mem_rdata;
		endcase
	end

	// Walk over the map: the byte read last cycle belongs to addr_q.
	assign hit      = (mem_rdata != ppba_pkg::BYTE_FULL);
	assign at_last  = (addr_q == LAST);
	assign scan_end = (op_q == ppba_pkg::CMD_FIND) ? (hit || at_last) : at_last;
	assign acc_next = acc_q + CNT_W'(ppba_pkg::zero_count(mem_rdata));

	// Read port: first read at accept, then one group per cycle while walking.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = addr_q + AW'(1);
		if (accept) begin
			mem_re = 1'b1;
			case (command)
				ppba_pkg::CMD_FIND:  mem_raddr = start_addr;
				ppba_pkg::CMD_COUNT: mem_raddr = '0;
				default:             mem_raddr = page_addr;
			endcase
		end else if (state_q == ST_SCAN) begin
			mem_re = 1'b1;
		end
	end

	// Write port: write-back of a claim or release, or the fill sweep.
	assign mem_we = ((state_q == ST_RMW) && in_range_q &&
		((op_q == ppba_pkg::CMD_CLAIM) || (op_q == ppba_pkg::CMD_RELEASE))) ||
		(state_q == ST_FILL);
	assign mem_waddr = (state_q == ST_FILL) ? fill_q : addr_q;
	assign mem_wdata = (state_q == ST_FILL) ? ppba_pkg::BYTE_FULL : new_byte;

	// Sequencer; the map is swept to all claimed after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q  <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (command)
							ppba_pkg::CMD_CLAIM_ALL: begin
								fill_q  <= '0;
								pend_q  <= 1'b1;
								state_q <= ST_FILL;
							end
							ppba_pkg::CMD_FIND:  state_q <= start_in ? ST_SCAN : ST_RMW;
							ppba_pkg::CMD_COUNT: state_q <= ST_SCAN;
							default:             state_q <= ST_RMW;
						endcase
					end
				end
				ST_RMW: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_FILL: begin
					fill_q <= fill_q + AW'(1);
					if (fill_q == LAST) begin
						state_q <= ST_IDLE;
						done_q  <= pend_q;
						pend_q  <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Operands, walk position, free count and result word.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= command;
			in_range_q <= page_in;
			bit_q      <= page[2:0];
			acc_q      <= '0;
			case (command)
				ppba_pkg::CMD_FIND:  addr_q <= start_addr;
				ppba_pkg::CMD_COUNT: addr_q <= '0;
				default:             addr_q <= page_addr;
			endcase
		end else if (state_q == ST_SCAN) begin
			addr_q <= addr_q + AW'(1);
			acc_q  <= acc_next;
		end

		if (state_q == ST_RMW) begin
			found_q      <= 1'b0;
			free_frame_q <= '0;
			free_count_q <= '0;
			if (single_op && in_range_q) begin
				group_bits_q <= new_byte;
				page_used_q  <= new_byte[bit_q];
			end else if (single_op) begin
				group_bits_q <= ppba_pkg::BYTE_FULL;
				page_used_q  <= 1'b1;
			end else begin
				group_bits_q <= '0;
				page_used_q  <= 1'b0;
			end
		end else if ((state_q == ST_SCAN) && scan_end) begin
			page_used_q  <= 1'b0;
			group_bits_q <= '0;
			if ((op_q == ppba_pkg::CMD_FIND) && hit) begin
				found_q      <= 1'b1;
				free_frame_q <= ppba_pkg::FRAME_W'({addr_q, ppba_pkg::lowest_zero(mem_rdata)});
			end else begin
				found_q      <= 1'b0;
				free_frame_q <= '0;
			end
			free_count_q <= (op_q == ppba_pkg::CMD_COUNT) ?
				ppba_pkg::COUNT_W'(acc_next) : '0;
		end else if ((state_q == ST_FILL) && (fill_q == LAST)) begin
			page_used_q  <= 1'b0;
			group_bits_q <= '0;
			found_q      <= 1'b0;
			free_frame_q <= '0;
			free_count_q <= '0;
		end
	end

	assign done       = done_q;
	assign page_used  = page_used_q;
	assign group_bits = group_bits_q;
	assign found      = found_q;
	assign free_frame = free_frame_q;
	assign free_count = free_count_q;

	// A result never shows in the cycle right after an accept.
	`PPBA_ASSERT_NEXT(a_no_early_done, clk, arst_n, accept, !done_q)
	// Results are only presented once the sequencer is back at rest.
	`PPBA_ASSERT_IMP(a_done_at_rest, clk, arst_n, done_q, state_q == ST_IDLE)
	// The map is written only by a write-back or by the fill sweep.
	`PPBA_ASSERT_IMP(a_write_source, clk, arst_n, mem_we, state_q == ST_RMW || state_q == ST_FILL)
	// A walk that has not ended moves to the next group.
	`PPBA_ASSERT_NEXT(a_walk_step, clk, arst_n, state_q == ST_SCAN && !scan_end, addr_q == $past(addr_q) + AW'(1))

endmodule

@@ sv/physical_page_bitmap_allocator_core.sv @@
// Top level of the physical page bitmap allocator: config register, sequencer and map memory.
//
//  Channel  | Handshake                 | Words
//  ---------+---------------------------+----------------------------------------------
//  command  | start high, busy low      | command, page
//  result   | done strobe, one cycle    | page_used, group_bits, found, free_frame,
//           |                           | free_count
//  config   | cfg_valid and cfg_ready   | search_start_group
//
// Check, claim, release and unknown commands go from accept through one memory read, then
// the modify, write-back and result register, to the done strobe.
// Find free walks the groups upward from the search start until one is not full or the last
// group is read; count free walks all PAGE_COUNT / 8 groups through the single read port.
// Claim all sweeps every group through the write port. After reset a fill pass writes every
// group claimed; busy is high meanwhile. Configuration writes are taken in every cycle.
// The receiver cannot stall: done is high for exactly one cycle per command.
module physical_page_bitmap_allocator_core #(
	parameter int PAGE_COUNT = ppba_pkg::PAGE_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ppba_pkg::CMD_W-1:0]     command,
	input  logic [ppba_pkg::PAGE_W-1:0]    page,
	output logic                           done,
	output logic                           page_used,
	output logic [7:0]                     group_bits,
	output logic                           found,
	output logic [ppba_pkg::FRAME_W-1:0]   free_frame,
	output logic [ppba_pkg::COUNT_W-1:0]   free_count,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ppba_pkg::GROUP_W-1:0]   search_start_group
);

	localparam int GROUP_COUNT = PAGE_COUNT / 8;
	localparam int AW = $clog2(GROUP_COUNT);

	logic [ppba_pkg::GROUP_W-1:0] start_group_q;
	logic mem_re;
	logic mem_we;
	logic [AW-1:0] mem_raddr;
	logic [AW-1:0] mem_waddr;
	logic [7:0] mem_rdata;
	logic [7:0] mem_wdata;

	// Search start register; always ready for a write.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_group_q <= ppba_pkg::START_RESET;
		end else if (cfg_valid && cfg_ready) begin
			start_group_q <= search_start_group;
		end
	end

	// Command sequencer.
	ppba_ctrl #(
		.PAGE_COUNT(PAGE_COUNT)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.command    (command),
		.page       (page),
		.start_group(start_group_q),
		.busy       (busy),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.done       (done),
		.page_used  (page_used),
		.group_bits (group_bits),
		.found      (found),
		.free_frame (free_frame),
		.free_count (free_count)
	);

	// Page map, one byte per group of eight pages.
	ppba_map_ram #(
		.DEPTH(GROUP_COUNT),
		.AW   (AW)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

@@ bench/ppba_result_checker.sv @@
// Result checker for the page bitmap allocator: tracks the map, predicts every result word and compares.
`timescale 1ns / 100ps

module ppba_result_checker
	import ppba_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [CMD_W-1:0]   command,
	input  logic [PAGE_W-1:0]  page,
	input  logic               done,
	input  logic               page_used,
	input  logic [7:0]         group_bits,
	input  logic               found,
	input  logic [FRAME_W-1:0] free_frame,
	input  logic [COUNT_W-1:0] free_count,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [GROUP_W-1:0] cfg_group,
	output int                 failures,
	output int                 outstanding
);

	localparam int GROUP_COUNT = PAGE_COUNT_DEF / 8;

	// One result word as the block reports it.
	typedef struct packed {
		logic               page_used;
		logic [7:0]         group_bits;
		logic               found;
		logic [FRAME_W-1:0] free_frame;
		logic [COUNT_W-1:0] free_count;
	} alloc_result_t;

	// Shadow copy of the page map and the search start.
	logic [7:0]         used_bytes [GROUP_COUNT];
	logic [GROUP_W-1:0] first_group;

	// Results predicted for accepted commands, oldest first.
	alloc_result_t      pending_results [$];
	alloc_result_t      want;
	int                 results_seen;

	// Apply one command to the shadow map and return the result word it gives.
	function automatic alloc_result_t apply_command(input logic [CMD_W-1:0] cmd,
			input logic [PAGE_W-1:0] pg);
		alloc_result_t r;
		logic [GROUP_W-1:0] g;
		logic [7:0] mask;
		int n;
		r = '0;
		g = pg[PAGE_W-1:3];
		mask = 8'd1 << pg[2:0];
		case (cmd)
			CMD_CHECK, CMD_CLAIM, CMD_RELEASE: begin
				if (cmd == CMD_CLAIM) begin
					used_bytes[g] = used_bytes[g] | mask;
				end else if (cmd == CMD_RELEASE) begin
					used_bytes[g] = used_bytes[g] & ~mask;
				end
				r.group_bits = used_bytes[g];
				r.page_used = |(used_bytes[g] & mask);
			end
			CMD_FIND: begin
				// Walk upward from the start group; the first byte that is not full wins.
				for (int grp = first_group; grp < GROUP_COUNT && !r.found; grp++) begin
					if (used_bytes[grp] != BYTE_FULL) begin
						r.found = 1'b1;
						for (int b = 0; b < 8; b++) begin
							if (!used_bytes[grp][b]) begin
								r.free_frame = FRAME_W'(grp * 8 + b);
								break;
							end
						end
					end
				end
			end
			CMD_COUNT: begin
				n = 0;
				foreach (used_bytes[i]) begin
					n += 8 - $countones(used_bytes[i]);
				end
				r.free_count = COUNT_W'(n);
			end
			CMD_CLAIM_ALL: begin
				foreach (used_bytes[i]) begin
					used_bytes[i] = BYTE_FULL;
				end
			end
			default: begin
				// Unknown commands leave the map alone and report all zeros.
			end
		endcase
		return r;
	endfunction

	// Compare one field of a result word; only the first few mismatches are shown.
	task automatic compare_field(input string name, input logic [COUNT_W-1:0] exp_val,
			input logic [COUNT_W-1:0] act_val);
		if (exp_val !== act_val) begin
			if (failures < 10) begin
				$display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, name,
					exp_val, act_val);
			end
			failures++;
		end
	endtask

	// Sample both channels at each rising edge; the result is handled before a new command.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (used_bytes[i]) begin
				used_bytes[i] = BYTE_FULL;
			end
			first_group = START_RESET;
			pending_results.delete();
			outstanding = 0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					if (failures < 10) begin
						$display("result %0d: word arrived with no command waiting",
							results_seen);
					end
					failures++;
				end else begin
					want = pending_results.pop_front();
					compare_field("page_used", COUNT_W'(want.page_used), COUNT_W'(page_used));
					compare_field("group_bits", COUNT_W'(want.group_bits),
						COUNT_W'(group_bits));
					compare_field("found", COUNT_W'(want.found), COUNT_W'(found));
					compare_field("free_frame", COUNT_W'(want.free_frame),
						COUNT_W'(free_frame));
					compare_field("free_count", want.free_count, free_count);
				end
				results_seen++;
			end
			if (start && !busy) begin
				pending_results.push_back(apply_command(command, page));
			end
			if (cfg_valid && cfg_ready) begin
				first_group = cfg_group;
			end
			outstanding = pending_results.size();
		end
	end

endmodule

@@ bench/tb.sv @@
// Testbench top for the page bitmap allocator: clock, reset, command and config stimulus, verdict.
`timescale 1ns / 100ps

module tb;
	import ppba_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [CMD_W-1:0]   command;
	logic [PAGE_W-1:0]  page;
	logic               done;
	logic               page_used;
	logic [7:0]         group_bits;
	logic               found;
	logic [FRAME_W-1:0] free_frame;
	logic [COUNT_W-1:0] free_count;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [GROUP_W-1:0] cfg_group;
	int                 failures;
	int                 outstanding;

	// When set, the command side never pauses.
	bit                 calm;

	physical_page_bitmap_allocator_core uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.command            (command),
		.page               (page),
		.done               (done),
		.page_used          (page_used),
		.group_bits         (group_bits),
		.found              (found),
		.free_frame         (free_frame),
		.free_count         (free_count),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.search_start_group (cfg_group)
	);

	ppba_result_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.page        (page),
		.done        (done),
		.page_used   (page_used),
		.group_bits  (group_bits),
		.found       (found),
		.free_frame  (free_frame),
		.free_count  (free_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_group   (cfg_group),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// 20 ns clock.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Hard stop in case the block hangs; even a full map walk for every word ends well before this.
	initial begin
		#1_000_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Issue one command word; sometimes pause first, then hold it until busy is low at an edge.
	task automatic issue(input logic [CMD_W-1:0] cmd, input logic [PAGE_W-1:0] pg);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		start = 1'b1;
		command = cmd;
		page = pg;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Drop start and wait until every predicted word has come back and the block is free.
	task automatic quiesce();
		@(negedge clk);
		start = 1'b0;
		while (outstanding != 0 || busy) @(negedge clk);
	endtask

	// Write the search start group while the block is idle.
	task automatic write_start_group(input logic [GROUP_W-1:0] grp);
		quiesce();
		cfg_valid = 1'b1;
		cfg_group = grp;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Random commands with pages mostly in a window just above the search start, so that
	// releases feed the search and finds stay short.
	task automatic run_phase(input logic [GROUP_W-1:0] grp, input int n_items);
		int base;
		int sel;
		logic [CMD_W-1:0] cmd;
		logic [PAGE_W-1:0] pg;
		write_start_group(grp);
		base = int'(grp) * 8;
		repeat (n_items) begin
			sel = $urandom_range(0, 99);
			if (sel < 20) cmd = CMD_CHECK;
			else if (sel < 45) cmd = CMD_CLAIM;
			else if (sel < 75) cmd = CMD_RELEASE;
			else if (sel < 89) cmd = CMD_FIND;
			else if (sel < 92) cmd = CMD_COUNT;
			else if (sel < 93) cmd = CMD_CLAIM_ALL;
			else if (sel < 96) cmd = CMD_W'($urandom_range(6, 7));
			else cmd = CMD_RELEASE;
			sel = $urandom_range(0, 9);
			if (sel < 7) begin
				pg = PAGE_W'(base + $urandom_range(0, 511));
			end else if (sel < 9) begin
				pg = PAGE_W'($urandom);
			end else begin
				case ($urandom_range(0, 2))
					0: pg = '0;
					1: pg = '1;
					default: pg = PAGE_W'(base);
				endcase
			end
			issue(cmd, pg);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_CHECK;
		page = '0;
		cfg_valid = 1'b0;
		cfg_group = START_RESET;
		calm = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Fresh map is fully claimed: nothing free, nothing found.
		quiesce();
		issue(CMD_COUNT, '0);
		issue(CMD_FIND, '0);
		issue(CMD_CHECK, '0);
		issue(CMD_CHECK, 16'hFFFF);

		// Free a few pages with alternating bit patterns and look for them.
		issue(CMD_RELEASE, '0);
		issue(CMD_RELEASE, 16'hFFFF);
		issue(CMD_RELEASE, 16'hAAAA);
		issue(CMD_RELEASE, 16'h5555);
		issue(CMD_CHECK, '0);
		issue(CMD_FIND, '0);
		issue(CMD_COUNT, '0);
		issue(CMD_CLAIM, 16'h5555);
		issue(CMD_RELEASE, 16'd2051);
		issue(CMD_FIND, '0);

		// Unknown commands change nothing.
		issue(CMD_W'(6), 16'hFFFF);
		issue(CMD_W'(7), '0);

		// Search from the bottom of the map.
		write_start_group('0);
		issue(CMD_FIND, '0);
		issue(CMD_CLAIM, '0);
		issue(CMD_FIND, '0);

		// Search only the top group, then with it full.
		write_start_group('1);
		issue(CMD_FIND, '0);
		issue(CMD_CLAIM, 16'hFFFF);
		issue(CMD_FIND, '0);

		// Claim everything and confirm the map is full again.
		issue(CMD_CLAIM_ALL, '0);
		issue(CMD_COUNT, '0);
		issue(CMD_CHECK, 16'hAAAA);

		// Random phases over several search starts, extremes included.
		run_phase('0, 120);
		run_phase('1, 80);
		run_phase(START_RESET, 120);
		run_phase(GROUP_W'($urandom), 120);
		run_phase(GROUP_W'($urandom_range(0, 1023)), 120);
		calm = 1'b1;
		run_phase(GROUP_W'($urandom_range(0, 8191)), 150);

		// Drain, then leave room for any stray result word.
		quiesce();
		repeat (20) @(negedge clk);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
